[hw/rtl/jmh_pkg.sv]
package jmh_pkg;

  // Initial value of the a and b accumulators
  localparam logic [31:0] GoldenRatio = 32'h9e37_79b9;

  // Word and byte-count sizes of one input beat
  localparam int unsigned WordW    = 32;
  localparam int unsigned CountW   = 3;
  localparam logic [CountW-1:0] FullCount = CountW'(4);

  // Word slots inside a 12-byte group
  localparam logic [1:0] SlotA = 2'd0;
  localparam logic [1:0] SlotB = 2'd1;
  localparam logic [1:0] SlotC = 2'd2;

  // Mix sequencing: nine dependent steps, one per cycle unless the output stalls
  localparam int unsigned MixSteps = 9;
  localparam int unsigned StepW    = $clog2(MixSteps);
  localparam logic [StepW-1:0] StepLast = StepW'(MixSteps - 1);

  // Group queue between front and back
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);
  localparam logic [QPtrW-1:0] QPtrLast = QPtrW'(QDepth - 1);

  // One 12-byte group, classified by the front
  typedef struct packed {
    logic [WordW-1:0] w0;
    logic [WordW-1:0] w1;
    logic [WordW-1:0] w2;
    logic [WordW-1:0] seed;
    logic             start;      // first group of a key: load initial values
    logic             group_mix;  // full group: mix before the closing mix
    logic             close;      // last group of a key: closing mix and result
  } grp_t;

  typedef struct packed {
    logic [WordW-1:0] a;
    logic [WordW-1:0] b;
    logic [WordW-1:0] c;
  } abc_t;

  // Queue status seen by the front
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [4:0] mix_shift(input logic [StepW-1:0] idx);
    logic [4:0] sh;
    case (idx)
      StepW'(0): sh = 5'd13;
      StepW'(1): sh = 5'd8;
      StepW'(2): sh = 5'd13;
      StepW'(3): sh = 5'd12;
      StepW'(4): sh = 5'd16;
      StepW'(5): sh = 5'd5;
      StepW'(6): sh = 5'd3;
      StepW'(7): sh = 5'd10;
      default:   sh = 5'd15;
    endcase
    return sh;
  endfunction

  // One step of the mix: update a, b or c in rotation
  function automatic abc_t mix_step(input logic [StepW-1:0] idx, input abc_t v);
    abc_t       r;
    logic [4:0] sh;
    r  = v;
    sh = mix_shift(idx);
    case (idx)
      StepW'(0), StepW'(3), StepW'(6): r.a = (v.a - v.b - v.c) ^ (v.c >> sh);
      StepW'(1), StepW'(4), StepW'(7): r.b = (v.b - v.c - v.a) ^ (v.a << sh);
      default:                         r.c = (v.c - v.a - v.b) ^ (v.b >> sh);
    endcase
    return r;
  endfunction

  // Keep the first count bytes of a word, zero the rest
  function automatic logic [WordW-1:0] byte_mask(input logic [CountW-1:0] cnt);
    logic [WordW-1:0] m;
    case (cnt)
      CountW'(0): m = 32'h0000_0000;
      CountW'(1): m = 32'h0000_00ff;
      CountW'(2): m = 32'h0000_ffff;
      CountW'(3): m = 32'h00ff_ffff;
      default:    m = 32'hffff_ffff;
    endcase
    return m;
  endfunction

endpackage

[hw/rtl/jmh_front.sv]
module jmh_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [jmh_pkg::WordW-1:0]    data_word_i,
  input  logic [jmh_pkg::CountW-1:0]   byte_count_i,
  input  logic                         last_i,
  input  logic [jmh_pkg::WordW-1:0]    seed_i,
  input  jmh_pkg::q_stat_t             q_stat_i,
  output logic                         push_o,
  output jmh_pkg::grp_t                grp_o
);
  import jmh_pkg::*;

  logic              in_key_q, in_key_d;
  logic              head_q, head_d;
  logic [1:0]        slot_q, slot_d;
  logic [WordW-1:0]  w0_q, w1_q, seed_q;
  logic              accept;
  logic [CountW-1:0] cnt_eff;
  logic [WordW-1:0]  word_m;
  logic              full_word;

  assign in_ready_o = !q_stat_i.full;
  assign accept     = in_valid_i && in_ready_o;

  // Saturate the byte count; non-last beats are always four bytes
  always_comb begin
    if (!last_i || (byte_count_i > FullCount)) begin
      cnt_eff = FullCount;
    end else begin
      cnt_eff = byte_count_i;
    end
  end

  assign word_m    = data_word_i & byte_mask(cnt_eff);
  assign full_word = (cnt_eff == FullCount);

  // Emit a group on the third word or at the end of a key
  assign push_o = accept && ((slot_q == SlotC) || last_i);

  always_comb begin
    grp_o.w0        = (slot_q == SlotA) ? word_m : w0_q;
    grp_o.w1        = (slot_q == SlotA) ? '0 : ((slot_q == SlotB) ? word_m : w1_q);
    grp_o.w2        = (slot_q == SlotC) ? word_m : '0;
    grp_o.seed      = in_key_q ? seed_q : seed_i;
    grp_o.start     = head_q;
    grp_o.group_mix = (slot_q == SlotC) && full_word;
    grp_o.close     = last_i;
  end

  // Advance slot and key tracking
  always_comb begin
    slot_d   = slot_q;
    in_key_d = in_key_q;
    head_d   = head_q;
    if (accept) begin
      in_key_d = !last_i;
      if (last_i || (slot_q == SlotC)) begin
        slot_d = SlotA;
      end else begin
        slot_d = slot_q + 2'd1;
      end
      if (push_o) begin
        head_d = last_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_key_q <= 1'b0;
      head_q   <= 1'b1;
      slot_q   <= SlotA;
    end else begin
      in_key_q <= in_key_d;
      head_q   <= head_d;
      slot_q   <= slot_d;
    end
  end

  // Hold partial group words and the key's seed
  always_ff @(posedge clk_i) begin
    if (accept && (slot_q == SlotA)) begin
      w0_q <= word_m;
    end
    if (accept && (slot_q == SlotB)) begin
      w1_q <= word_m;
    end
    if (accept && !in_key_q) begin
      seed_q <= seed_i;
    end
  end

endmodule

[hw/rtl/jmh_queue.sv]
module jmh_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  jmh_pkg::grp_t    grp_i,
  input  logic             pop_i,
  output jmh_pkg::grp_t    grp_o,
  output jmh_pkg::q_stat_t stat_o
);
  import jmh_pkg::*;

  grp_t             ent_q [QDepth];
  logic [QPtrW-1:0] wr_q, rd_q;
  logic [QCntW-1:0] cnt_q;
  logic             do_push, do_pop;

  assign stat_o.full  = (cnt_q == QCntW'(QDepth));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign grp_o        = ent_q[rd_q];

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == QPtrLast) ? '0 : wr_q + QPtrW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == QPtrLast) ? '0 : rd_q + QPtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + QCntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - QCntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      ent_q[wr_q] <= grp_i;
    end
  end

endmodule

[hw/rtl/jmh_mix.sv]
module jmh_mix (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  jmh_pkg::q_stat_t          q_stat_i,
  input  jmh_pkg::grp_t             grp_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [jmh_pkg::WordW-1:0] hash_o
);
  import jmh_pkg::*;

  logic             busy_q, second_q, close_q, out_valid_q;
  logic [StepW-1:0] step_q;
  abc_t             acc_q, step_res;
  logic [WordW-1:0] hash_q;
  logic             mix_done, out_free, advance, emit;

  assign pop_o    = !busy_q && !q_stat_i.empty;
  assign step_res = mix_step(step_q, acc_q);
  assign mix_done = busy_q && (step_q == StepLast) && !second_q;
  assign out_free = !out_valid_q || out_ready_i;
  // Stall the final step of a closing mix while the output register is still occupied
  assign advance  = busy_q && !(mix_done && close_q && !out_free);
  assign emit     = advance && mix_done && close_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      step_q      <= '0;
      second_q    <= 1'b0;
      close_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        busy_q   <= 1'b1;
        step_q   <= '0;
        second_q <= grp_i.group_mix && grp_i.close;
        close_q  <= grp_i.close;
      end else if (advance) begin
        if (step_q == StepLast) begin
          step_q <= '0;
          if (second_q) begin
            second_q <= 1'b0;
          end else begin
            busy_q <= 1'b0;
          end
        end else begin
          step_q <= step_q + StepW'(1);
        end
      end
      // Hold the result until it is taken
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Load a group into the accumulators, then run the mix steps
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      acc_q.a <= (grp_i.start ? GoldenRatio : acc_q.a) + grp_i.w0;
      acc_q.b <= (grp_i.start ? GoldenRatio : acc_q.b) + grp_i.w1;
      acc_q.c <= (grp_i.start ? grp_i.seed : acc_q.c) + grp_i.w2;
    end else if (advance) begin
      acc_q <= step_res;
    end
    if (emit) begin
      hash_q <= step_res.c;
    end
  end

  assign out_valid_o = out_valid_q;
  assign hash_o      = hash_q;

endmodule

[hw/rtl/jenkins_mix_hash32.sv]
// Path: last beat of a key, group queue, mix steps, output register; a last beat
//   completing a full 12-byte group gets a group mix before the closing mix.
// Throughput: one beat per cycle unless the 4-group queue is full; the mix unit
//   runs one step per cycle unless its output stalls; it sets the sustained rate.
// Reset: rst_ni clears key tracking, queue pointers, mix sequencer and output valid.
module jenkins_mix_hash32 (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [jmh_pkg::WordW-1:0]    data_word_i,
  input  logic [jmh_pkg::CountW-1:0]   byte_count_i,
  input  logic                         last_i,
  input  logic [jmh_pkg::WordW-1:0]    seed_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [jmh_pkg::WordW-1:0]    hash_o
);
  import jmh_pkg::*;

  logic    push, pop;
  grp_t    grp_in, grp_head;
  q_stat_t q_stat;

  // Collect words into groups
  jmh_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .data_word_i  (data_word_i),
    .byte_count_i (byte_count_i),
    .last_i       (last_i),
    .seed_i       (seed_i),
    .q_stat_i     (q_stat),
    .push_o       (push),
    .grp_o        (grp_in)
  );

  // Buffer groups between front and mix unit
  jmh_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .grp_i  (grp_in),
    .pop_i  (pop),
    .grp_o  (grp_head),
    .stat_o (q_stat)
  );

  // Accumulate and mix
  jmh_mix u_mix (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_stat_i    (q_stat),
    .grp_i       (grp_head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .hash_o      (hash_o)
  );

endmodule

[hw/rtl/jmh_checker.sv]
module jmh_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_o,
  input logic                      last_i,
  input logic                      out_valid_o,
  input logic                      out_ready_i,
  input logic [jmh_pkg::WordW-1:0] hash_o
);
  import jmh_pkg::*;

  localparam int unsigned PendW = $clog2(QDepth + 3) + 1;

  logic             in_last_beat, out_beat;
  logic [PendW-1:0] pend_q;

  assign in_last_beat = in_valid_i && in_ready_o && last_i;
  assign out_beat     = out_valid_o && out_ready_i;

  // Track keys whose hash is still owed
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else if (in_last_beat && !out_beat) begin
      pend_q <= pend_q + PendW'(1);
    end else if (out_beat && !in_last_beat) begin
      pend_q <= pend_q - PendW'(1);
    end
  end

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // A stalled hash keeps its value
  a_hash_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(hash_o))
    else $error("hash changed while stalled");

  // Every result belongs to a key whose last beat was taken
  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (pend_q != '0))
    else $error("result without a finished key");

  // Keys in flight never exceed queue plus mix and output stages
  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= PendW'(QDepth + 2))
    else $error("too many keys in flight");

endmodule

bind jenkins_mix_hash32 jmh_checker u_jmh_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .last_i      (last_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .hash_o      (hash_o)
);
